>>> hdl/dpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the double pendulum derivative pipeline.
// No dependencies; imported by every module of the block.
package dpd_pkg;

  typedef struct packed {
    logic signed [31:0] upper_angle;
    logic signed [31:0] lower_angle;
    logic signed [31:0] upper_momentum;
    logic signed [31:0] lower_momentum;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] upper_angle_rate;
    logic signed [31:0] lower_angle_rate;
    logic signed [31:0] upper_momentum_rate;
    logic signed [31:0] lower_momentum_rate;
    logic               overflow;
  } out_word_t;

  localparam int GRAV_W = 22;
  localparam logic [GRAV_W-1:0] GRAV_RESET = 22'd642253;

  // round(2^32 / (2 pi)), turns per radian scaled
  localparam logic signed [31:0] INV_TWO_PI = 32'sd683565276;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // sine polynomial coefficients in Q30, highest order first
  localparam int SIN_NK = 5;
  localparam logic [31:0] SIN_K [SIN_NK] = '{
    32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };
  localparam int SIN_LAT = SIN_NK + 1;

  // divider: magnitude of 24*num*2^20 fits 60 bits, quotient 40 bits
  localparam int DIV_MAG_W = 60;
  localparam int DIV_QW    = 40;
  localparam int DIV_DEN_W = 25;
  localparam int DIV_PER   = 4;
  localparam int DIV_LAT   = DIV_QW / DIV_PER;

  localparam logic [DIV_DEN_W-1:0] DEN_MIN = 25'd7340032;   // 7 in Q20
  localparam logic [DIV_DEN_W-1:0] DEN_MAX = 25'd16777216;  // 16 in Q20

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // clamp to 32 bits; bit 32 reports saturation
  function automatic logic [32:0] sat32(input logic signed [66:0] x);
    logic [32:0] res;
    if (x > 67'sh0_7FFF_FFFF) begin
      res = {1'b1, SAT_MAX};
    end else if (x < -67'sh0_8000_0000) begin
      res = {1'b1, SAT_MIN};
    end else begin
      res = {1'b0, x[31:0]};
    end
    return res;
  endfunction

endpackage

>>> hdl/dpd_sine.sv
`timescale 1ns / 1ps
// Pipelined fixed-point sine of a phase in turns, Q30 result.
// Depends on dpd_pkg for the polynomial coefficients.
module dpd_sine import dpd_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase,
  output logic signed [31:0] sin_q30
);

  localparam int NH = SIN_NK - 1;

  logic [30:0] z_r  [0:NH];
  logic [30:0] z2_r [0:NH-1];
  logic [31:0] t_r  [1:NH];
  logic        neg_r[0:NH];
  logic [31:0] out_r;

  logic [30:0] z0;
  logic [61:0] zz;

  assign z0 = phase[30] ? (ONE_Q30 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
  assign zz = z0 * z0;

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0]   <= z0;
      z2_r[0]  <= zz[60:30];
      neg_r[0] <= phase[31];
    end
  end

  // Horner steps, one per stage
  for (genvar h = 1; h <= NH; h++) begin : g_horner
    logic [31:0] tin;
    logic [62:0] prod;
    if (h == 1) begin : g_first
      assign tin = SIN_K[0];
    end else begin : g_next
      assign tin = t_r[h-1];
    end
    assign prod = z2_r[h-1] * tin;
    always_ff @(posedge clk) begin
      if (en) begin
        t_r[h]   <= SIN_K[h] - prod[61:30];
        z_r[h]   <= z_r[h-1];
        neg_r[h] <= neg_r[h-1];
      end
    end
    if (h < NH) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          z2_r[h] <= z2_r[h-1];
        end
      end
    end
  end

  logic [62:0] sp;
  logic [31:0] mag;
  assign sp  = z_r[NH] * t_r[NH];
  assign mag = (sp[62:30] > {2'b0, ONE_Q30}) ? {1'b0, ONE_Q30} : sp[61:30];

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= neg_r[NH] ? (32'd0 - mag) : mag;
    end
  end

  assign sin_q30 = $signed(out_r);

endmodule

>>> hdl/dpd_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, four quotient bits per stage.
// Depends on dpd_pkg for widths and stage count.
module dpd_div import dpd_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_MAG_W-1:0] mag,
  input  logic [DIV_DEN_W-1:0] den,
  input  logic                 neg,
  output logic [DIV_QW-1:0]    quo,
  output logic                 quo_neg
);

  localparam int TOP_W = DIV_MAG_W - DIV_QW;

  logic [DIV_DEN_W-1:0] rem_r [0:DIV_LAT-1];
  logic [DIV_QW-1:0]    w_r   [0:DIV_LAT-1];
  logic [DIV_DEN_W-1:0] den_r [0:DIV_LAT-1];
  logic                 neg_r [0:DIV_LAT-1];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [DIV_DEN_W-1:0] rem_in;
    logic [DIV_QW-1:0]    w_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic                 neg_in;
    logic [DIV_DEN_W-1:0] rem_out;
    logic [DIV_QW-1:0]    w_out;

    if (k == 0) begin : g_head
      assign rem_in = {{(DIV_DEN_W-TOP_W){1'b0}}, mag[DIV_MAG_W-1:DIV_QW]};
      assign w_in   = mag[DIV_QW-1:0];
      assign den_in = den;
      assign neg_in = neg;
    end else begin : g_body
      assign rem_in = rem_r[k-1];
      assign w_in   = w_r[k-1];
      assign den_in = den_r[k-1];
      assign neg_in = neg_r[k-1];
    end

    always_comb begin
      logic [DIV_DEN_W:0] cand;
      rem_out = rem_in;
      w_out   = w_in;
      for (int j = 0; j < DIV_PER; j++) begin
        cand = {rem_out, w_out[DIV_QW-1]};
        if (cand >= {1'b0, den_in}) begin
          cand  = cand - {1'b0, den_in};
          w_out = {w_out[DIV_QW-2:0], 1'b1};
        end else begin
          w_out = {w_out[DIV_QW-2:0], 1'b0};
        end
        rem_out = cand[DIV_DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_out;
        w_r[k]   <= w_out;
        den_r[k] <= den_in;
        neg_r[k] <= neg_in;
      end
    end
  end

  assign quo     = w_r[DIV_LAT-1];
  assign quo_neg = neg_r[DIV_LAT-1];

endmodule

>>> hdl/double_pendulum_derivative_top.sv
`timescale 1ns / 1ps
// Double pendulum derivative pipeline.
// Throughput one word per cycle; the whole pipe holds while the output word is stalled.
// Depth is set by the six-stage sine units and the ten-stage divider.
// Synchronous active-low reset clears the valid bits and loads gravity with 9.8.
// Depends on dpd_pkg, dpd_sine and dpd_div.
module double_pendulum_derivative_top import dpd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              cfg_we,
  input  logic [GRAV_W-1:0] cfg_wdata
);

  localparam int ST_B   = 1 + SIN_LAT;
  localparam int ST_C   = ST_B + 1;
  localparam int ST_D   = ST_C + DIV_LAT + 1;
  localparam int LAT    = ST_D + 4;
  localparam int S_DLY  = DIV_LAT + 2;

  logic              en;
  logic [LAT-1:0]    vld_r;
  logic [GRAV_W-1:0] grav_r;

  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      grav_r <= GRAV_RESET;
    end else begin
      if (en) begin
        vld_r <= {vld_r[LAT-2:0], in_valid};
      end
      if (cfg_we) begin
        grav_r <= cfg_wdata;
      end
    end
  end

  // ---- stage A: angle reduction to phase
  logic signed [32:0] d_ang;
  logic signed [63:0] prod_d, prod_1, prod_2;
  logic [31:0]        ph_d_r, ph_1_r, ph_2_r;
  logic signed [31:0] p_dly1 [0:SIN_LAT];
  logic signed [31:0] p_dly2 [0:SIN_LAT];

  assign d_ang  = 33'(in_data.upper_angle) - 33'(in_data.lower_angle);
  assign prod_d = d_ang * INV_TWO_PI;
  assign prod_1 = in_data.upper_angle * INV_TWO_PI;
  assign prod_2 = in_data.lower_angle * INV_TWO_PI;

  always_ff @(posedge clk) begin
    if (en) begin
      ph_d_r    <= prod_d[FRAC_BITS+31 -: 32];
      ph_1_r    <= prod_1[FRAC_BITS+31 -: 32];
      ph_2_r    <= prod_2[FRAC_BITS+31 -: 32];
      p_dly1[0] <= in_data.upper_momentum;
      p_dly2[0] <= in_data.lower_momentum;
      for (int i = 1; i <= SIN_LAT; i++) begin
        p_dly1[i] <= p_dly1[i-1];
        p_dly2[i] <= p_dly2[i-1];
      end
    end
  end

  // ---- sine units
  logic signed [31:0] sd, cd, s1, s2;
  logic [31:0]        ph_c;
  assign ph_c = ph_d_r + QUARTER_TURN;

  dpd_sine u_sin_d (.clk(clk), .en(en), .phase(ph_d_r), .sin_q30(sd));
  dpd_sine u_cos_d (.clk(clk), .en(en), .phase(ph_c),   .sin_q30(cd));
  dpd_sine u_sin_1 (.clk(clk), .en(en), .phase(ph_1_r), .sin_q30(s1));
  dpd_sine u_sin_2 (.clk(clk), .en(en), .phase(ph_2_r), .sin_q30(s2));

  // hold sines until the momentum stages need them
  logic signed [31:0] sd_dly [0:S_DLY];
  logic signed [31:0] s1_dly [0:S_DLY-1];
  logic signed [31:0] s2_dly [0:S_DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_dly[0] <= sd;
      s1_dly[0] <= s1;
      s2_dly[0] <= s2;
      for (int i = 1; i < S_DLY; i++) begin
        s1_dly[i] <= s1_dly[i-1];
        s2_dly[i] <= s2_dly[i-1];
      end
      for (int i = 1; i <= S_DLY; i++) begin
        sd_dly[i] <= sd_dly[i-1];
      end
    end
  end

  // ---- stage B: cos products
  logic [63:0]        cc;
  logic signed [63:0] cp1, cp2;
  logic [30:0]        c2_r;
  logic signed [32:0] cp1_r, cp2_r;
  logic signed [31:0] p1_b_r, p2_b_r;

  assign cc  = cd * cd;
  assign cp1 = cd * p_dly1[SIN_LAT];
  assign cp2 = cd * p_dly2[SIN_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r   <= cc[60:30];
      cp1_r  <= cp1[62:30];
      cp2_r  <= cp2[62:30];
      p1_b_r <= p_dly1[SIN_LAT];
      p2_b_r <= p_dly2[SIN_LAT];
    end
  end

  // ---- stage C: denominator and scaled numerators
  logic [34:0]          den_full;
  logic signed [35:0]   num0, num1;
  logic [34:0]          abs0, abs1;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_MAG_W-1:0] mag0_r, mag1_r;
  logic                 neg0_r, neg1_r;

  assign den_full = 35'h4_0000_0000 - (35'(c2_r) * 35'd9);
  assign num0 = (36'(p1_b_r) <<< 1) - 36'(cp2_r) * 36'sd3;
  assign num1 = (36'(p2_b_r) <<< 3) - 36'(cp1_r) * 36'sd3;
  assign abs0 = num0[35] ? 35'(-num0) : num0[34:0];
  assign abs1 = num1[35] ? 35'(-num1) : num1[34:0];

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= den_full[34:10];
      mag0_r <= {40'(abs0) * 40'd24, 20'd0};
      mag1_r <= {40'(abs1) * 40'd24, 20'd0};
      neg0_r <= num0[35];
      neg1_r <= num1[35];
    end
  end

  // ---- divider
  logic [DIV_QW-1:0] q0, q1;
  logic              qn0, qn1;

  dpd_div u_div0 (.clk(clk), .en(en), .mag(mag0_r), .den(den_r), .neg(neg0_r),
                  .quo(q0), .quo_neg(qn0));
  dpd_div u_div1 (.clk(clk), .en(en), .mag(mag1_r), .den(den_r), .neg(neg1_r),
                  .quo(q1), .quo_neg(qn1));

  // ---- stage D: angle rate saturation, gravity terms
  logic signed [40:0] v0, v1;
  logic [32:0]        sat0, sat1;
  logic signed [53:0] g1p, g2p;
  logic signed [31:0] r0_d_r, r1_d_r;
  logic               ov_d_r;
  logic signed [23:0] gs1_d_r, gs2_d_r;

  assign v0   = qn0 ? -$signed({1'b0, q0}) : $signed({1'b0, q0});
  assign v1   = qn1 ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
  assign sat0 = sat32(67'(v0));
  assign sat1 = sat32(67'(v1));
  assign g1p  = $signed({1'b0, grav_r}) * s1_dly[S_DLY-1];
  assign g2p  = $signed({1'b0, grav_r}) * s2_dly[S_DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      r0_d_r  <= $signed(sat0[31:0]);
      r1_d_r  <= $signed(sat1[31:0]);
      ov_d_r  <= sat0[32] | sat1[32];
      gs1_d_r <= g1p[53:30];
      gs2_d_r <= g2p[53:30];
    end
  end

  // ---- stage E: r0 * sin d
  logic signed [63:0] m_prod;
  logic signed [32:0] m_e_r;
  logic signed [31:0] r0_e_r, r1_e_r;
  logic               ov_e_r;
  logic signed [23:0] gs1_e_r, gs2_e_r;

  assign m_prod = r0_d_r * sd_dly[S_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      m_e_r   <= m_prod[62:30];
      r0_e_r  <= r0_d_r;
      r1_e_r  <= r1_d_r;
      ov_e_r  <= ov_d_r;
      gs1_e_r <= gs1_d_r;
      gs2_e_r <= gs2_d_r;
    end
  end

  // ---- stage F: times r1
  logic signed [64:0] q_prod;
  logic signed [64:0] q_f_r;
  logic signed [31:0] r0_f_r, r1_f_r;
  logic               ov_f_r;
  logic signed [23:0] gs1_f_r, gs2_f_r;

  assign q_prod = m_e_r * r1_e_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_f_r   <= q_prod >>> FRAC_BITS;
      r0_f_r  <= r0_e_r;
      r1_f_r  <= r1_e_r;
      ov_f_r  <= ov_e_r;
      gs1_f_r <= gs1_e_r;
      gs2_f_r <= gs2_e_r;
    end
  end

  // ---- stage G: momentum rates, output register
  logic signed [66:0] x2, x3;
  logic [32:0]        sat2, sat3;
  out_word_t          out_r;

  assign x2   = -(67'(q_f_r) + 67'(gs1_f_r) * 67'sd6);
  assign x3   = 67'(q_f_r) - 67'(gs2_f_r) * 67'sd2;
  assign sat2 = sat32(x2 >>> 3);
  assign sat3 = sat32(x3 >>> 3);

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.upper_angle_rate    <= r0_f_r;
      out_r.lower_angle_rate    <= r1_f_r;
      out_r.upper_momentum_rate <= $signed(sat2[31:0]);
      out_r.lower_momentum_rate <= $signed(sat3[31:0]);
      out_r.overflow            <= ov_f_r | sat2[32] | sat3[32];
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_r;

  // ---- checks
  a_den_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_C] |-> (den_r >= DEN_MIN && den_r <= DEN_MAX))
    else $error("denominator out of range");

  a_sine_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_B-1] |-> (sd <= 32'sh4000_0000 && sd >= -32'sh4000_0000 &&
                       cd <= 32'sh4000_0000 && cd >= -32'sh4000_0000))
    else $error("sine beyond unit range");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflow) |->
      (out_data.upper_angle_rate == SAT_MAX || out_data.upper_angle_rate == SAT_MIN ||
       out_data.lower_angle_rate == SAT_MAX || out_data.lower_angle_rate == SAT_MIN ||
       out_data.upper_momentum_rate == SAT_MAX ||
       out_data.upper_momentum_rate == SAT_MIN ||
       out_data.lower_momentum_rate == SAT_MAX ||
       out_data.lower_momentum_rate == SAT_MIN))
    else $error("overflow flag without a clamped rate");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for double_pendulum_derivative_top: directed and random state vectors,
// a bit-exact derivative predictor and a scoreboard. Depends on dpd_pkg and the RTL.
module tb_top;
  import dpd_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 22;
  localparam longint LIMIT = 400000;
  localparam longint TURNS_PER_RAD = 683565276;
  localparam longint Q30 = 64'sd1 << 30;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [GRAV_W-1:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;

  always #5 clk = ~clk;

  double_pendulum_derivative_top #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  function automatic longint floor_shift(longint x, int k);
    return x >>> k;
  endfunction

  function automatic logic [31:0] angle_phase(longint a);
    longint p;
    p = a * TURNS_PER_RAD;
    return p[FRAC+31:FRAC];
  endfunction

  function automatic longint sine_q30(logic [31:0] ph);
    longint z, z2, t, s;
    z = ph[29:0];
    if (ph[30]) z = Q30 - z;
    z2 = (z * z) >>> 30;
    t = 172272;
    t = 5026995 - ((z2 * t) >>> 30);
    t = 85569306 - ((z2 * t) >>> 30);
    t = 693598668 - ((z2 * t) >>> 30);
    t = 1686629713 - ((z2 * t) >>> 30);
    s = (z * t) >>> 30;
    if (s > Q30) s = Q30;
    return ph[31] ? -s : s;
  endfunction

  function automatic longint clamp32(longint x, ref logic ov);
    if (x > 64'sd2147483647) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      ov = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic out_word_t pendulum_rates(in_word_t w, logic [GRAV_W-1:0] grav);
    longint t1, t2, p1, p2, g, sd, cd, s1, s2, c2, den, n0, n1, r0, r1, q, gs1, gs2;
    logic [31:0] pd;
    logic ov;
    out_word_t r;
    t1 = w.upper_angle; t2 = w.lower_angle;
    p1 = w.upper_momentum; p2 = w.lower_momentum;
    g = grav;
    ov = 1'b0;
    pd = angle_phase(t1 - t2);
    sd = sine_q30(pd);
    cd = sine_q30(pd + QUARTER_TURN);
    s1 = sine_q30(angle_phase(t1));
    s2 = sine_q30(angle_phase(t2));
    c2 = (cd * cd) >>> 30;
    den = (16 * Q30 - 9 * c2) >>> 10;
    n0 = 2 * p1 - 3 * floor_shift(cd * p2, 30);
    n1 = 8 * p2 - 3 * floor_shift(cd * p1, 30);
    r0 = clamp32((24 * n0 * (64'sd1 <<< 20)) / den, ov);
    r1 = clamp32((24 * n1 * (64'sd1 <<< 20)) / den, ov);
    q = floor_shift(floor_shift(r0 * sd, 30) * r1, FRAC);
    gs1 = floor_shift(g * s1, 30);
    gs2 = floor_shift(g * s2, 30);
    r.upper_angle_rate = r0[31:0];
    r.lower_angle_rate = r1[31:0];
    r.upper_momentum_rate = 32'(clamp32(floor_shift(-(q + 6 * gs1), 3), ov));
    r.lower_momentum_rate = 32'(clamp32(floor_shift(q - 2 * gs2, 3), ov));
    r.overflow = ov;
    return r;
  endfunction

  class rate_scoreboard;
    out_word_t pending[$];
    logic [GRAV_W-1:0] gravity = GRAV_RESET;
    int mismatches = 0;

    function void note_input(in_word_t w);
      pending.push_back(pendulum_rates(w, gravity));
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %h %h %h %h ov%b got %h %h %h %h ov%b",
                   want.upper_angle_rate, want.lower_angle_rate,
                   want.upper_momentum_rate, want.lower_momentum_rate, want.overflow,
                   got.upper_angle_rate, got.lower_angle_rate,
                   got.upper_momentum_rate, got.lower_momentum_rate, got.overflow);
      end
    endfunction
  endclass

  rate_scoreboard sb = new();

  // sample at the rising edge, drive the stall at the falling edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(negedge clk)
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk)
    if (cycles > LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end

  // valid stays up between back-to-back words; drop it only while idling
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic set_gravity(logic [GRAV_W-1:0] g);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.gravity = g;
  endtask

  function automatic logic [31:0] pick_field();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sd1 <<< $urandom_range(30);
      2: return -($urandom_range(32'h0007_FFFF));
      3: return $urandom_range(32'h0007_FFFF);
      4: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic random_words(int n);
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      w.upper_angle = pick_field();
      w.lower_angle = pick_field();
      w.upper_momentum = pick_field();
      w.lower_momentum = pick_field();
      send_word(w);
    end
  endtask

  initial begin
    in_word_t w;
    logic [31:0] edges[6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'h0001_921F};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, quarter turns, equal angles, huge momenta
    for (int i = 0; i < 6; i++) begin
      w.upper_angle = edges[i];
      w.lower_angle = edges[(i + 1) % 6];
      w.upper_momentum = edges[(i + 2) % 6];
      w.lower_momentum = edges[(i + 3) % 6];
      send_word(w);
      w = '{edges[i], edges[i], edges[5 - i], edges[i]};
      send_word(w);
    end
    send_word('{32'h0001_921F, 32'hFFFE_6DE1, 32'h0001_0000, 32'h0002_0000});
    send_word('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    // hold off until the pipe is empty
    drain();

    set_gravity(GRAV_W'(0));
    random_words(30);
    set_gravity({GRAV_W{1'b1}});
    send_word('{32'h0000_4000, 32'hFFFF_C000, 32'h0, 32'h0});
    random_words(30);
    set_gravity(GRAV_W'(2097152));
    random_words(30);
    set_gravity(GRAV_RESET);

    for (int ph = PH_FREE; ph <= PH_BOTH; ph++) begin
      case (idle_phase_t'(ph))
        PH_FREE: begin send_idle_pct = 0; recv_stall_pct = 0; end
        PH_SEND_IDLE: begin send_idle_pct = 87; recv_stall_pct = 0; end
        PH_RECV_STALL: begin send_idle_pct = 0; recv_stall_pct = 87; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      random_words(80);
      if (ph == PH_RECV_STALL) set_gravity(GRAV_W'($urandom));
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

>>> sim.f
hdl/dpd_pkg.sv
hdl/dpd_sine.sv
hdl/dpd_div.sv
hdl/double_pendulum_derivative_top.sv
verif/tb_top.sv
